/* src/gdfo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfo_pkg
// Shared widths, codes and controller/datapath types of the depth-first
// search block.
// ----------------------------------------------------------------------------
package gdfo_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int VTX_W            = 7;
	localparam int TIME_W           = 8;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 7;

	localparam logic [VTX_W-1:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		FUNC_ADD_ARC  = 2'd0,
		FUNC_ADD_EDGE = 2'd1,
		FUNC_CLEAR    = 2'd2,
		FUNC_ORDER    = 2'd3
	} func_t;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_TRANSPOSED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARC_RD,
		ST_ARC_WR,
		ST_START_RD,
		ST_START_CHK,
		ST_ROW_RD,
		ST_ROW_CHK,
		ST_POP,
		ST_EMIT_SET,
		ST_EMIT_RD,
		ST_EMIT_TBL,
		ST_EMIT_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic arc_rd;
		logic arc_wr;
		logic arc_swap;
		logic start_rd;
		logic start_take;
		logic next_start;
		logic row_rd;
		logic push;
		logic finish;
		logic pop_take;
		logic emit_set;
		logic emit_rd;
		logic emit_tbl;
		logic emit_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic arc_go;
		logic walk_go;
		logic second_pass;
		logic start_ok;
		logic k_last;
		logic has_cand;
		logic depth_zero;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

/* src/gdfo_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfo_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface gdfo_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic [gdfo_pkg::VTX_W-1:0] tail_vertex;
	logic [gdfo_pkg::VTX_W-1:0] head_vertex;
	logic [gdfo_pkg::VTX_W-1:0] order_vertex;

	modport source (output valid, func, tail_vertex, head_vertex, order_vertex, input ready);
	modport sink (input valid, func, tail_vertex, head_vertex, order_vertex, output ready);
endinterface

// ----------------------------------------------------------------------------
// gdfo_out_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface gdfo_out_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [gdfo_pkg::VTX_W-1:0]  vertex;
	logic [gdfo_pkg::TIME_W-1:0] discover_time;
	logic [gdfo_pkg::TIME_W-1:0] finish_time;
	logic [gdfo_pkg::VTX_W-1:0]  parent_vertex;
	logic                        last;

	modport source (output valid, status, vertex, discover_time, finish_time,
		parent_vertex, last, input ready);
	modport sink (input valid, status, vertex, discover_time, finish_time,
		parent_vertex, last, output ready);
endinterface

/* src/gdfo_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfo_ctrl
// Sequencer for arc updates, the depth-first walk and result emission.
// ----------------------------------------------------------------------------
module gdfo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gdfo_pkg::stat_t   st,
	output gdfo_pkg::cmd_t    cmd
);

	gdfo_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdfo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gdfo_pkg::ST_IDLE: begin
				in_ready = st.out_free;
				if (in_valid && st.out_free) begin
					cmd.take = 1'b1;
					if (st.arc_go) state_d = gdfo_pkg::ST_ARC_RD;
					else if (st.walk_go) state_d = gdfo_pkg::ST_START_RD;
				end
			end
			gdfo_pkg::ST_ARC_RD: begin
				cmd.arc_rd = 1'b1;
				state_d    = gdfo_pkg::ST_ARC_WR;
			end
			gdfo_pkg::ST_ARC_WR: begin
				cmd.arc_wr = 1'b1;
				if (st.second_pass) begin
					cmd.arc_swap = 1'b1;
					state_d      = gdfo_pkg::ST_ARC_RD;
				end else begin
					state_d = gdfo_pkg::ST_IDLE;
				end
			end
			gdfo_pkg::ST_START_RD: begin
				cmd.start_rd = 1'b1;
				state_d      = gdfo_pkg::ST_START_CHK;
			end
			gdfo_pkg::ST_START_CHK: begin
				if (st.start_ok) begin
					cmd.start_take = 1'b1;
					state_d        = gdfo_pkg::ST_ROW_RD;
				end else if (st.k_last) begin
					state_d = gdfo_pkg::ST_EMIT_SET;
				end else begin
					cmd.next_start = 1'b1;
					state_d        = gdfo_pkg::ST_START_RD;
				end
			end
			gdfo_pkg::ST_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = gdfo_pkg::ST_ROW_CHK;
			end
			gdfo_pkg::ST_ROW_CHK: begin
				if (st.has_cand) begin
					cmd.push = 1'b1;
					state_d  = gdfo_pkg::ST_ROW_RD;
				end else begin
					cmd.finish = 1'b1;
					if (!st.depth_zero) state_d = gdfo_pkg::ST_POP;
					else if (st.k_last) state_d = gdfo_pkg::ST_EMIT_SET;
					else begin
						cmd.next_start = 1'b1;
						state_d        = gdfo_pkg::ST_START_RD;
					end
				end
			end
			gdfo_pkg::ST_POP: begin
				cmd.pop_take = 1'b1;
				state_d      = gdfo_pkg::ST_ROW_RD;
			end
			gdfo_pkg::ST_EMIT_SET: begin
				cmd.emit_set = 1'b1;
				state_d      = gdfo_pkg::ST_EMIT_RD;
			end
			gdfo_pkg::ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = gdfo_pkg::ST_EMIT_TBL;
			end
			gdfo_pkg::ST_EMIT_TBL: begin
				cmd.emit_tbl = 1'b1;
				state_d      = gdfo_pkg::ST_EMIT_OUT;
			end
			gdfo_pkg::ST_EMIT_OUT: begin
				if (st.out_free) begin
					cmd.emit_out = 1'b1;
					state_d = st.emit_last ? gdfo_pkg::ST_IDLE : gdfo_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = gdfo_pkg::ST_IDLE;
		endcase
	end

endmodule

/* src/gdfo_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfo_datapath
// Adjacency memories, walk stack, time tables, counters and result register.
// ----------------------------------------------------------------------------
module gdfo_datapath #(
	parameter int MAX_VERTICES = gdfo_pkg::MAX_VERTICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gdfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gdfo_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]                      in_func,
	input  logic [gdfo_pkg::VTX_W-1:0]      in_tail,
	input  logic [gdfo_pkg::VTX_W-1:0]      in_head,
	input  logic [gdfo_pkg::VTX_W-1:0]      in_order,
	input  gdfo_pkg::cmd_t                  cmd,
	output gdfo_pkg::stat_t                 st,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_status,
	output logic [gdfo_pkg::VTX_W-1:0]      out_vertex,
	output logic [gdfo_pkg::TIME_W-1:0]     out_discover,
	output logic [gdfo_pkg::TIME_W-1:0]     out_finish,
	output logic [gdfo_pkg::VTX_W-1:0]      out_parent,
	output logic                            out_last
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VW = gdfo_pkg::VTX_W;
	localparam int TW = gdfo_pkg::TIME_W;

	typedef logic [MAX_VERTICES-1:0] row_t;

	// configuration
	logic [VW-1:0] vcount_q;
	logic          transp_q;

	// adjacency, forward and transposed
	row_t fwd_mem [MAX_VERTICES];
	row_t trn_mem [MAX_VERTICES];
	row_t fvalid_q, tvalid_q;
	row_t fwd_rd_q, trn_rd_q;
	logic fwd_rv_q, trn_rv_q;
	logic [AW-1:0] arc_a_q, arc_b_q;
	logic          undir_q, swapped_q;

	// run order
	logic [VW-1:0] order_mem [MAX_VERTICES];
	logic [VW-1:0] order_rd_q;
	logic [AW:0]   fill_q;

	// walk
	row_t          visited_q;
	logic [TW-1:0] time_q;
	logic [AW-1:0] k_q, top_q, depth_q;
	logic [AW-1:0] stack_mem [MAX_VERTICES];
	logic [AW-1:0] stack_rd_q;
	logic [AW:0]   fc_q;
	logic [AW-1:0] fstack_mem [MAX_VERTICES];
	logic [AW-1:0] fstack_rd_q;
	logic [AW-1:0] j_q;

	// per-vertex tables
	logic [TW-1:0] disc_mem [MAX_VERTICES];
	logic [TW-1:0] fin_mem [MAX_VERTICES];
	logic [VW-1:0] par_mem [MAX_VERTICES];
	logic [TW-1:0] disc_rd_q, fin_rd_q;
	logic [VW-1:0] par_rd_q, vtx_rd_q;

	// result register
	logic          ovalid_q, ostatus_q, olast_q;
	logic [VW-1:0] overtex_q, oparent_q;
	logic [TW-1:0] odisc_q, ofin_q;

	// combinational
	logic [VW-1:0] n;
	row_t          nmask, row_sel, cand;
	logic [AW-1:0] found;
	logic          tail_ok, head_ok, order_ok, item_bad, fill_done, trigger;
	logic [VW-1:0] tail_m1, head_m1, start_m1;
	logic [AW-1:0] start_idx;
	logic [TW-1:0] time_nx;
	logic          ack_load;

	function automatic logic in_range(input logic [VW-1:0] v, input logic [VW-1:0] cnt);
		in_range = (v != '0) && (v <= cnt);
	endfunction

	// effective vertex count
	always_comb begin
		if (vcount_q == '0) n = VW'(1);
		else if (32'(vcount_q) > MAX_VERTICES) n = VW'(MAX_VERTICES);
		else n = vcount_q;
	end

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) nmask[i] = (i < int'(n));
	end

	// decode the incoming word
	assign tail_m1   = in_tail - 1'b1;
	assign head_m1   = in_head - 1'b1;
	assign tail_ok   = in_range(in_tail, n);
	assign head_ok   = in_range(in_head, n);
	assign order_ok  = in_range(in_order, n);
	assign fill_done = (int'(fill_q) + 1) >= int'(n);

	always_comb begin
		item_bad = 1'b0;
		case (gdfo_pkg::func_t'(in_func)) inside
			gdfo_pkg::FUNC_ADD_ARC, gdfo_pkg::FUNC_ADD_EDGE: item_bad = !(tail_ok && head_ok);
			gdfo_pkg::FUNC_ORDER: item_bad = !order_ok;
			default: item_bad = 1'b0;
		endcase
	end

	assign trigger  = (gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ORDER) && order_ok
		&& fill_done;
	assign ack_load = cmd.take && !trigger;

	// neighbour search: lowest unvisited arc within range
	assign row_sel = transp_q ? (trn_rv_q ? trn_rd_q : '0) : (fwd_rv_q ? fwd_rd_q : '0);
	assign cand    = row_sel & ~visited_q & nmask;

	always_comb begin
		found = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) found = AW'(i);
		end
	end

	assign start_m1  = order_rd_q - 1'b1;
	assign start_idx = AW'(start_m1);
	assign time_nx   = time_q + 1'b1;

	// status to the controller
	always_comb begin
		st             = '0;
		st.arc_go      = !item_bad && (gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ADD_ARC
			|| gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ADD_EDGE);
		st.walk_go     = trigger;
		st.second_pass = undir_q && !swapped_q;
		st.start_ok    = in_range(order_rd_q, n) && !visited_q[start_idx];
		st.k_last      = (int'(k_q) + 1) >= int'(n);
		st.has_cand    = |cand;
		st.depth_zero  = (depth_q == '0);
		st.emit_last   = (j_q == '0);
		st.out_free    = !ovalid_q || out_ready;
	end

	// configuration, fill count and arc-valid rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gdfo_pkg::VCOUNT_RESET;
			transp_q <= 1'b0;
			fill_q   <= '0;
			fvalid_q <= '0;
			tvalid_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gdfo_pkg::CFG_VERTEX_COUNT: begin
						vcount_q <= cfg_data[VW-1:0];
						fill_q   <= '0;
					end
					gdfo_pkg::CFG_WALK_TRANSPOSED: transp_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take && gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_CLEAR) begin
				fvalid_q <= '0;
				tvalid_q <= '0;
			end
			if (cmd.take && gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ORDER && order_ok)
			begin
				fill_q <= fill_done ? '0 : fill_q + 1'b1;
			end
			if (cmd.arc_wr) begin
				fvalid_q[arc_a_q] <= 1'b1;
				tvalid_q[arc_b_q] <= 1'b1;
			end
		end
	end

	// arc endpoints for the read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			arc_a_q   <= AW'(tail_m1);
			arc_b_q   <= AW'(head_m1);
			undir_q   <= (gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ADD_EDGE);
			swapped_q <= 1'b0;
		end else if (cmd.arc_swap) begin
			arc_a_q   <= arc_b_q;
			arc_b_q   <= arc_a_q;
			swapped_q <= 1'b1;
		end
	end

	// adjacency memories: row read for updates and for the walk
	always_ff @(posedge clk) begin
		if (cmd.arc_rd) begin
			fwd_rd_q <= fwd_mem[arc_a_q];
			trn_rd_q <= trn_mem[arc_b_q];
			fwd_rv_q <= fvalid_q[arc_a_q];
			trn_rv_q <= tvalid_q[arc_b_q];
		end else if (cmd.row_rd) begin
			fwd_rd_q <= fwd_mem[top_q];
			trn_rd_q <= trn_mem[top_q];
			fwd_rv_q <= fvalid_q[top_q];
			trn_rv_q <= tvalid_q[top_q];
		end
		if (cmd.arc_wr) begin
			fwd_mem[arc_a_q] <= (fwd_rv_q ? fwd_rd_q : '0) | (row_t'(1) << arc_b_q);
			trn_mem[arc_b_q] <= (trn_rv_q ? trn_rd_q : '0) | (row_t'(1) << arc_a_q);
		end
	end

	// run order memory
	always_ff @(posedge clk) begin
		if (cmd.take && gdfo_pkg::func_t'(in_func) == gdfo_pkg::FUNC_ORDER && order_ok) begin
			order_mem[fill_q[AW-1:0]] <= in_order;
		end
		if (cmd.start_rd) order_rd_q <= order_mem[k_q];
	end

	// walk counters and colour bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else begin
			if (cmd.take && trigger) time_q <= '0;
			else if (cmd.start_take || cmd.push || cmd.finish) time_q <= time_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && trigger) begin
			visited_q <= '0;
			k_q       <= '0;
			depth_q   <= '0;
			fc_q      <= '0;
		end
		if (cmd.next_start) k_q <= k_q + 1'b1;
		if (cmd.start_take) begin
			visited_q[start_idx] <= 1'b1;
			top_q                <= start_idx;
		end
		if (cmd.push) begin
			visited_q[found] <= 1'b1;
			depth_q          <= depth_q + 1'b1;
			top_q            <= found;
		end
		if (cmd.finish) begin
			fc_q <= fc_q + 1'b1;
			if (depth_q != '0) depth_q <= depth_q - 1'b1;
		end
		if (cmd.pop_take) top_q <= stack_rd_q;
		if (cmd.emit_set) j_q <= AW'(fc_q - 1'b1);
		if (cmd.emit_out) j_q <= j_q - 1'b1;
	end

	// walk stack and finish stack
	always_ff @(posedge clk) begin
		if (cmd.push) stack_mem[depth_q] <= top_q;
		if (cmd.finish) stack_rd_q <= stack_mem[depth_q - 1'b1];
		if (cmd.finish) fstack_mem[fc_q[AW-1:0]] <= top_q;
		if (cmd.emit_rd) fstack_rd_q <= fstack_mem[j_q];
	end

	// discover, finish and parent tables
	always_ff @(posedge clk) begin
		if (cmd.start_take) begin
			disc_mem[start_idx] <= time_nx;
			par_mem[start_idx]  <= '0;
		end
		if (cmd.push) begin
			disc_mem[found] <= time_nx;
			par_mem[found]  <= VW'(top_q) + 1'b1;
		end
		if (cmd.finish) fin_mem[top_q] <= time_nx;
		if (cmd.emit_tbl) begin
			disc_rd_q <= disc_mem[fstack_rd_q];
			fin_rd_q  <= fin_mem[fstack_rd_q];
			par_rd_q  <= par_mem[fstack_rd_q];
			vtx_rd_q  <= VW'(fstack_rd_q) + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (ack_load || cmd.emit_out) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack_load) begin
			ostatus_q <= item_bad;
			overtex_q <= '0;
			odisc_q   <= '0;
			ofin_q    <= '0;
			oparent_q <= '0;
			olast_q   <= 1'b1;
		end else if (cmd.emit_out) begin
			ostatus_q <= 1'b0;
			overtex_q <= vtx_rd_q;
			odisc_q   <= disc_rd_q;
			ofin_q    <= fin_rd_q;
			oparent_q <= par_rd_q;
			olast_q   <= (j_q == '0);
		end
	end

	assign out_valid    = ovalid_q;
	assign out_status   = ostatus_q;
	assign out_vertex   = overtex_q;
	assign out_discover = odisc_q;
	assign out_finish   = ofin_q;
	assign out_parent   = oparent_q;
	assign out_last     = olast_q;

endmodule

/* src/graph_dfs_finish_order_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_finish_order_top
// Depth-first search over a stored directed graph, results in decreasing
// finish order with discover time, finish time and parent.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  in_ch     in   valid / ready    func, tail_vertex, head_vertex, order_vertex
//  out_ch    out  valid / ready    status, vertex, times, parent_vertex, last
//  cfg       in   cfg_we           cfg_index, cfg_data
//
//  Clear, error and plain order words: acknowledge registered.
//  Arc and undirected edge: read-modify-write of two row memories, per direction.
//  Final order word: order read and check per start, row read and check per
//  walk step, then finish-stack read, table read and output per result.
//  Reset clears the arc-valid rows at once; no clearing pass.
//  A stalled result holds the walk in its emit step only.
// ----------------------------------------------------------------------------
module graph_dfs_finish_order_top #(
	parameter int MAX_VERTICES = gdfo_pkg::MAX_VERTICES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gdfo_in_if.sink                         in_ch,
	gdfo_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [gdfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gdfo_pkg::CFG_DATA_W-1:0] cfg_data
);

	gdfo_pkg::cmd_t  cmd;
	gdfo_pkg::stat_t st;

	gdfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	gdfo_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_func      (in_ch.func),
		.in_tail      (in_ch.tail_vertex),
		.in_head      (in_ch.head_vertex),
		.in_order     (in_ch.order_vertex),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_status   (out_ch.status),
		.out_vertex   (out_ch.vertex),
		.out_discover (out_ch.discover_time),
		.out_finish   (out_ch.finish_time),
		.out_parent   (out_ch.parent_vertex),
		.out_last     (out_ch.last)
	);

endmodule

/* bench/graph_dfs_finish_order_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_finish_order_top_tb
// Self-checking bench for the depth-first search block. Graph loads, clears,
// run orders and bad vertices go in through a queued driver. A local copy of
// the graph predicts every acknowledge and every finish-ordered search
// record. A monitor checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module graph_dfs_finish_order_top_tb;

	localparam int NV          = gdfo_pkg::MAX_VERTICES_DEF;
	localparam int VW          = gdfo_pkg::VTX_W;
	localparam int TW          = gdfo_pkg::TIME_W;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		gdfo_pkg::func_t func;
		logic [VW-1:0]   tail;
		logic [VW-1:0]   head;
		logic [VW-1:0]   ordv;
	} cmd_word_t;

	typedef struct packed {
		logic          status;
		logic [VW-1:0] vertex;
		logic [TW-1:0] disc;
		logic [TW-1:0] fin;
		logic [VW-1:0] parent;
		logic          last;
	} res_word_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [gdfo_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [gdfo_pkg::CFG_DATA_W-1:0]     cfg_data;

	gdfo_in_if  in_ch ();
	gdfo_out_if out_ch ();

	graph_dfs_finish_order_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the block state
	logic [NV-1:0] graph_rows [1:NV];
	logic [VW-1:0] vcount_reg;
	logic          transposed_reg;
	int            order_len;
	int            order_list [NV];

	cmd_word_t pending_cmds [$];
	res_word_t expected_res [$];
	cmd_word_t cur_cmd;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        fail_count;
	int        cycle_count;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int active_count();
		if (vcount_reg == 0) return 1;
		if (vcount_reg > NV) return NV;
		return int'(vcount_reg);
	endfunction

	function automatic bit arc_on(int a, int b);
		return transposed_reg ? graph_rows[b][a-1] : graph_rows[a][b-1];
	endfunction

	function automatic res_word_t ack_word(logic st);
		res_word_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// walk the graph and queue every visited vertex in decreasing finish order
	task automatic queue_search_records();
		int n, sp, fc, x, y, found, s;
		int colour [1:NV];
		int par [1:NV];
		int dsc [1:NV];
		int fin [1:NV];
		int stk [NV];
		int fstk [NV];
		logic [TW-1:0] clock_val;
		res_word_t r;
		n = active_count();
		fc = 0;
		clock_val = '0;
		for (int i = 1; i <= n; i++) begin
			colour[i] = 0;
			par[i] = 0;
		end
		for (int k = 0; k < n; k++) begin
			s = order_list[k];
			if (s < 1 || s > n || colour[s] != 0) continue;
			colour[s] = 1;
			clock_val++;
			dsc[s] = clock_val;
			sp = 0;
			stk[sp++] = s;
			while (sp > 0) begin
				x = stk[sp-1];
				found = 0;
				for (y = 1; y <= n; y++) begin
					if (arc_on(x, y) && colour[y] == 0) begin
						found = y;
						break;
					end
				end
				if (found != 0 && sp < NV) begin
					par[found] = x;
					colour[found] = 1;
					clock_val++;
					dsc[found] = clock_val;
					stk[sp++] = found;
				end else begin
					colour[x] = 2;
					clock_val++;
					fin[x] = clock_val;
					if (fc < NV) fstk[fc++] = x;
					sp--;
				end
			end
		end
		for (int k = 0; k < fc; k++) begin
			x = fstk[fc-1-k];
			r.status = 1'b0;
			r.vertex = VW'(x);
			r.disc = TW'(dsc[x]);
			r.fin = TW'(fin[x]);
			r.parent = VW'(par[x]);
			r.last = (k + 1 == fc);
			expected_res.push_back(r);
		end
	endtask

	// apply one accepted command word to the local state
	task automatic predict_command(cmd_word_t c);
		int n;
		n = active_count();
		case (c.func)
			gdfo_pkg::FUNC_CLEAR: begin
				for (int i = 1; i <= NV; i++) graph_rows[i] = '0;
				expected_res.push_back(ack_word(1'b0));
			end
			gdfo_pkg::FUNC_ORDER: begin
				if (c.ordv < 1 || c.ordv > n) begin
					expected_res.push_back(ack_word(1'b1));
				end else begin
					if (order_len < NV) order_list[order_len] = int'(c.ordv);
					order_len++;
					if (order_len >= n) begin
						order_len = 0;
						queue_search_records();
					end else begin
						expected_res.push_back(ack_word(1'b0));
					end
				end
			end
			default: begin
				if (c.tail < 1 || c.tail > n || c.head < 1 || c.head > n) begin
					expected_res.push_back(ack_word(1'b1));
				end else begin
					graph_rows[c.tail][c.head-1] = 1'b1;
					if (c.func == gdfo_pkg::FUNC_ADD_EDGE) graph_rows[c.head][c.tail-1] = 1'b1;
					expected_res.push_back(ack_word(1'b0));
				end
			end
		endcase
	endtask

	// driver: present queued words, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.func <= gdfo_pkg::FUNC_ADD_ARC;
			in_ch.tail_vertex <= '0;
			in_ch.head_vertex <= '0;
			in_ch.order_vertex <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) predict_command(cur_cmd);
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.func <= cur_cmd.func;
					in_ch.tail_vertex <= cur_cmd.tail;
					in_ch.head_vertex <= cur_cmd.head;
					in_ch.order_vertex <= cur_cmd.ordv;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result word, stall at random
	always @(posedge clk or negedge arst_n) begin
		res_word_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_res.size() == 0) begin
					$error("unexpected result word, vertex %0d", out_ch.vertex);
					fail_count++;
				end else begin
					e = expected_res.pop_front();
					if (out_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_ch.status);
						fail_count++;
					end
					if (out_ch.vertex !== e.vertex) begin
						$error("vertex exp %0d got %0d", e.vertex, out_ch.vertex);
						fail_count++;
					end
					if (out_ch.discover_time !== e.disc) begin
						$error("discover_time exp %0d got %0d", e.disc, out_ch.discover_time);
						fail_count++;
					end
					if (out_ch.finish_time !== e.fin) begin
						$error("finish_time exp %0d got %0d", e.fin, out_ch.finish_time);
						fail_count++;
					end
					if (out_ch.parent_vertex !== e.parent) begin
						$error("parent_vertex exp %0d got %0d", e.parent, out_ch.parent_vertex);
						fail_count++;
					end
					if (out_ch.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_ch.last);
						fail_count++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("graph_dfs_finish_order_top regression: fail");
			$finish;
		end
	end

	task automatic push_cmd(gdfo_pkg::func_t f, int t, int h, int o);
		cmd_word_t c;
		c.func = f;
		c.tail = VW'(t);
		c.head = VW'(h);
		c.ordv = VW'(o);
		pending_cmds.push_back(c);
	endtask

	// hold until every word is sent and every result is back, then let it settle
	task automatic drain();
		while (pending_cmds.size() > 0 || in_ch.valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [gdfo_pkg::CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= gdfo_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gdfo_pkg::CFG_VERTEX_COUNT) begin
			vcount_reg = VW'(val);
			order_len = 0;
		end else begin
			transposed_reg = val[0];
		end
	endtask

	// a random graph load followed by a full run order
	task automatic queue_random_walk(int n);
		int arcs;
		arcs = $urandom_range(2 * n + 2);
		for (int i = 0; i < arcs; i++) begin
			case ($urandom_range(19))
				0: push_cmd(gdfo_pkg::FUNC_CLEAR, $urandom_range(127), $urandom_range(127), 0);
				1: push_cmd(gdfo_pkg::func_t'($urandom_range(1)), $urandom_range(127),
					$urandom_range(127), $urandom_range(127));
				2, 3, 4, 5, 6: push_cmd(gdfo_pkg::FUNC_ADD_EDGE, $urandom_range(n, 1),
					$urandom_range(n, 1), $urandom_range(127));
				default: push_cmd(gdfo_pkg::FUNC_ADD_ARC, $urandom_range(n, 1),
					$urandom_range(n, 1), $urandom_range(127));
			endcase
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, $urandom_range(127));
			push_cmd(gdfo_pkg::FUNC_ORDER, $urandom_range(127), $urandom_range(127),
				$urandom_range(n, 1));
		end
	endtask

	initial begin
		int n, phase_items, vc;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_index = gdfo_pkg::CFG_VERTEX_COUNT;
		cfg_data = '0;
		for (int i = 1; i <= NV; i++) graph_rows[i] = '0;
		vcount_reg = gdfo_pkg::VCOUNT_RESET;
		transposed_reg = 1'b0;
		order_len = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, bad vertices, clear, at reset settings
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 1, 64, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_EDGE, 64, 1, 127);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 0, 5, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_EDGE, 5, 65, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 127, 127, 127);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 0);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 65);
		push_cmd(gdfo_pkg::FUNC_ORDER, 127, 127, 127);
		push_cmd(gdfo_pkg::FUNC_CLEAR, 127, 127, 127);
		drain();
		// small graph, repeated start vertex, unreachable vertex, arc to a vertex beyond n
		write_reg(gdfo_pkg::CFG_VERTEX_COUNT, 4);
		write_reg(gdfo_pkg::CFG_WALK_TRANSPOSED, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 1, 2, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 2, 3, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 2, 1, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 2, 1, 0);
		push_cmd(gdfo_pkg::FUNC_ADD_ARC, 3, 5, 0);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 1);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 2);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 1);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 3);
		drain();
		write_reg(gdfo_pkg::CFG_WALK_TRANSPOSED, 1);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 3);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 4);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 2);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 1);
		drain();
		// count of zero acts as one
		write_reg(gdfo_pkg::CFG_VERTEX_COUNT, 0);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 2);
		push_cmd(gdfo_pkg::FUNC_ORDER, 0, 0, 1);
		drain();

		// random phases over every idling mode
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			case (p)
				3: vc = 64;
				7: vc = 100;
				10: vc = 1;
				default: vc = $urandom_range(9, 2);
			endcase
			write_reg(gdfo_pkg::CFG_VERTEX_COUNT, vc);
			write_reg(gdfo_pkg::CFG_WALK_TRANSPOSED, $urandom_range(1));
			n = active_count();
			phase_items = 0;
			while (phase_items < 14) begin
				int before_cnt;
				before_cnt = pending_cmds.size();
				queue_random_walk(n);
				phase_items += pending_cmds.size() - before_cnt;
				// in phase 5 the sender holds off until the block has answered everything
				if (p == 5) drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("graph_dfs_finish_order_top regression: pass");
		end else begin
			$display("graph_dfs_finish_order_top regression: fail");
		end
		$finish;
	end

endmodule
